// File: rtl/sjfq_pkg.sv
package sjfq_pkg;

    localparam int DEPTH  = 32;
    localparam int SIZE_W = 10;
    localparam int OCNT_W = 6;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_DAT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [SIZE_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic [SIZE_W-1:0] removed_size;
        logic              removed_valid;
        logic              insert_refused;
        logic              queue_full;
        logic              queue_empty;
        logic [OCNT_W-1:0] entry_count;
    } t_res;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
        return (x == '0) ? IDX_W'(DEPTH - 1) : x - 1'b1;
    endfunction

    // physical slot of logical position cnt in the ring starting at base
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(cnt);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return IDX_W'(s);
    endfunction

endpackage

// File: rtl/sjfq_ram.sv
module sjfq_ram
    import sjfq_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [SIZE_W-1:0] o_rdata
);

    logic [SIZE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// File: rtl/sjfq_ctrl.sv
module sjfq_ctrl
    import sjfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mode,
    input  logic [SIZE_W-1:0] i_job_size,
    input  logic              i_res_take,
    input  logic [SIZE_W-1:0] i_rdata,
    output t_ram_req          o_req,
    output logic              o_busy,
    output logic              o_res_valid,
    output t_res              o_res
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_wptr, n_wptr;
    logic [IDX_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_rem_size, n_rem_size;
    logic              r_rem_valid, n_rem_valid;
    logic              r_refused, n_refused;
    logic              full, empty, move_up;
    logic [IDX_W-1:0]  tail;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign move_up = (i_rdata > r_size);
    assign tail    = ring_add(r_base, r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_INSERT) begin
                        n_state = full ? ST_FIN : ST_INS_RD;
                    end else begin
                        n_state = empty ? ST_FIN : ST_REM_DAT;
                    end
                end
            end
            ST_INS_RD:  n_state = (r_left == '0) ? ST_FIN : ST_INS_CMP;
            ST_INS_CMP: n_state = move_up ? ST_INS_RD : ST_FIN;
            ST_REM_DAT: n_state = ST_FIN;
            ST_FIN:     n_state = i_res_take ? ST_IDLE : ST_FIN;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req       = '0;
        o_busy      = (r_state != ST_IDLE);
        o_res_valid = (r_state == ST_FIN);
        unique case (r_state)
            ST_IDLE:    o_req.raddr = r_base;   // head is ready if a remove comes
            ST_INS_RD: begin
                o_req.raddr = r_rptr;
                if (r_left == '0) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_wptr;
                    o_req.wdata = r_size;
                end
            end
            ST_INS_CMP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_wptr;
                o_req.wdata = move_up ? i_rdata : r_size;
            end
            ST_REM_DAT: o_req.raddr = r_base;
            ST_FIN:     o_req.raddr = r_base;
            default:    o_req = '0;
        endcase
    end

    assign o_res.removed_size   = r_rem_size;
    assign o_res.removed_valid  = r_rem_valid;
    assign o_res.insert_refused = r_refused;
    assign o_res.queue_full     = full;
    assign o_res.queue_empty    = empty;
    assign o_res.entry_count    = OCNT_W'(r_count);

    // datapath
    always_comb begin
        n_base      = r_base;
        n_count     = r_count;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_left      = r_left;
        n_size      = r_size;
        n_rem_size  = r_rem_size;
        n_rem_valid = r_rem_valid;
        n_refused   = r_refused;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_size      = i_job_size;
                    n_rem_size  = '0;
                    n_rem_valid = 1'b0;
                    n_refused   = (i_mode == MODE_INSERT) && full;
                    n_wptr      = tail;
                    n_rptr      = idx_dec(tail);
                    n_left      = r_count;
                end
            end
            ST_INS_RD: begin
                if (r_left == '0) begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_INS_CMP: begin
                if (move_up) begin
                    n_wptr = r_rptr;
                    n_rptr = idx_dec(r_rptr);
                    n_left = r_left - 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_REM_DAT: begin
                n_rem_size  = i_rdata;
                n_rem_valid = 1'b1;
                n_base      = idx_inc(r_base);
                n_count     = r_count - 1'b1;
            end
            ST_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wptr      <= n_wptr;
        r_rptr      <= n_rptr;
        r_left      <= n_left;
        r_size      <= n_size;
        r_rem_size  <= n_rem_size;
        r_rem_valid <= n_rem_valid;
        r_refused   <= n_refused;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_mode == MODE_INSERT && full)
        |=> (r_state == ST_FIN && r_refused && $stable(r_count)))
        else $error("insert into full queue not refused");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_CMP && move_up)
        |=> (r_state == ST_INS_RD && r_left == $past(r_left) - 1'b1))
        else $error("insert walk did not step back");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REM_DAT) |=> (r_count == $past(r_count) - 1'b1 && r_rem_valid))
        else $error("remove did not drop count");

endmodule

// File: rtl/shortest_job_first_queue.sv
// Channel | Handshake           | Payload
// --------+---------------------+--------------------------------------------
// in      | i_valid / o_stall   | i_mode, i_job_size
// out     | o_valid / i_stall   | o_removed_size, o_removed_valid,
//         |                     | o_insert_refused, o_queue_full,
//         |                     | o_queue_empty, o_entry_count
//
// Entries live in a ring in one RAM, one write and one registered read port.
// Remove reads the head and advances the ring base. Insert walks back from the
// tail, moving each entry larger than the new size up a slot (a RAM
// read-compare-write step for each), then writes the new size into the freed slot.
// Insert into a full queue or remove from an empty one goes straight to the result.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// The output register holds a result under i_stall; o_stall is high while an
// item is in progress or its result cannot yet be handed over.
module shortest_job_first_queue
    import sjfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [SIZE_W-1:0] i_job_size,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SIZE_W-1:0] o_removed_size,
    output logic              o_removed_valid,
    output logic              o_insert_refused,
    output logic              o_queue_full,
    output logic              o_queue_empty,
    output logic [OCNT_W-1:0] o_entry_count
);

    t_ram_req          ram_req;
    logic [SIZE_W-1:0] ram_rdata;
    logic              busy, res_valid, res_take, start;
    t_res              res;
    t_res              r_out;
    logic              r_out_valid;

    assign o_stall  = busy;
    assign start    = i_valid && !busy;
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    sjfq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    sjfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_job_size  (i_job_size),
        .i_res_take  (res_take),
        .i_rdata     (ram_rdata),
        .o_req       (ram_req),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_removed_size   = r_out.removed_size;
    assign o_removed_valid  = r_out.removed_valid;
    assign o_insert_refused = r_out.insert_refused;
    assign o_queue_full     = r_out.queue_full;
    assign o_queue_empty    = r_out.queue_empty;
    assign o_entry_count    = r_out.entry_count;

endmodule

// File: tb/testbench.sv
module testbench;
    import sjfq_pkg::*;

    localparam int N_RANDOM = 1300;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] size;
        logic              typed;
        t_res              res;
    } t_row;

    // typed rows carry the result to expect; for the others the predictor's result is expected
    localparam t_row DIRECTED [22] = '{
        '{MODE_REMOVE, 10'd0,    1'b1, '{10'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'd0}},
        '{MODE_INSERT, 10'd1023, 1'b1, '{10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 6'd1}},
        '{MODE_INSERT, 10'd0,    1'b1, '{10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 6'd2}},
        '{MODE_INSERT, 10'h155,  1'b0, '0},
        '{MODE_INSERT, 10'h2aa,  1'b0, '0},
        '{MODE_INSERT, 10'd512,  1'b0, '0},
        '{MODE_INSERT, 10'd512,  1'b0, '0},
        '{MODE_INSERT, 10'd1,    1'b0, '0},
        '{MODE_REMOVE, 10'd1023, 1'b1, '{10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 6'd6}},
        '{MODE_REMOVE, 10'd0,    1'b0, '0},
        '{MODE_REMOVE, 10'h2aa,  1'b0, '0},
        '{MODE_REMOVE, 10'h155,  1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b1, '{10'd1023, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0}},
        '{MODE_REMOVE, 10'h3ff,  1'b1, '{10'd0,    1'b0, 1'b0, 1'b0, 1'b1, 6'd0}},
        '{MODE_INSERT, 10'd7,    1'b0, '0},
        '{MODE_INSERT, 10'd7,    1'b0, '0},
        '{MODE_INSERT, 10'd3,    1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b0, '0},
        '{MODE_REMOVE, 10'd0,    1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_mode = MODE_INSERT;
    logic [SIZE_W-1:0] i_job_size = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [SIZE_W-1:0] o_removed_size;
    logic              o_removed_valid;
    logic              o_insert_refused;
    logic              o_queue_full;
    logic              o_queue_empty;
    logic [OCNT_W-1:0] o_entry_count;

    shortest_job_first_queue dut (.*);

    // predictor state: stored sizes, ascending, equal sizes in arrival order
    logic [SIZE_W-1:0] job_list[$];
    t_res              pending_results[$];

    int n_mismatch = 0;
    int n_stray = 0;
    int n_results = 0;
    int n_inserts = 0;
    int n_removes = 0;
    int n_refused = 0;
    int n_empty_takes = 0;
    int n_full = 0;
    int sender_quiet = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 1_000_000);
        $display("timeout: %0d results outstanding", pending_results.size());
        $display("testbench: errors");
        $finish;
    end

    function automatic t_res predict_job(input logic mode, input logic [SIZE_W-1:0] size);
        t_res r;
        int   pos;
        r = '0;
        if (mode == MODE_INSERT) begin
            n_inserts++;
            if (job_list.size() >= DEPTH) begin
                r.insert_refused = 1'b1;
                n_refused++;
            end else begin
                pos = job_list.size();
                while (pos > 0 && job_list[pos-1] > size) pos--;
                job_list.insert(pos, size);
            end
        end else begin
            n_removes++;
            if (job_list.size() > 0) begin
                r.removed_size  = job_list.pop_front();
                r.removed_valid = 1'b1;
            end else begin
                n_empty_takes++;
            end
        end
        r.queue_full  = (job_list.size() >= DEPTH);
        r.queue_empty = (job_list.size() == 0);
        r.entry_count = OCNT_W'(job_list.size());
        if (r.queue_full) n_full++;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet > 0) begin
            sender_quiet--;
            return 0;
        end
        if (r < 3) sender_quiet = $urandom_range(20, 120);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return SIZE_W'($urandom);
        if (r < 7) return SIZE_W'($urandom_range(0, 15));
        if (r < 8) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return SIZE_W'($urandom_range(1000, 1023));
    endfunction

    task automatic offer_job(input logic mode, input logic [SIZE_W-1:0] size,
                             input logic typed, input t_res typed_res);
        int   gap;
        t_res r;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_mode     = mode;
        i_job_size = size;
        do @(posedge i_clk); while (o_stall);
        r = predict_job(mode, size);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_pause();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_result();
        t_res want;
        t_res got;
        got = '{o_removed_size, o_removed_valid, o_insert_refused, o_queue_full,
                o_queue_empty, o_entry_count};
        n_results++;
        if (pending_results.size() == 0) begin
            n_stray++;
            if (n_stray + n_mismatch <= 10)
                $display("unexpected result: %p", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.removed_size !== want.removed_size || got.removed_valid !== want.removed_valid
            || got.insert_refused !== want.insert_refused
            || got.queue_full !== want.queue_full || got.queue_empty !== want.queue_empty
            || got.entry_count !== want.entry_count) begin
            n_mismatch++;
            if (n_stray + n_mismatch <= 10) begin
                $display("result %0d mismatch", n_results);
                $display("  size %0d/%0d valid %b/%b refused %b/%b (expected/actual)",
                         want.removed_size, got.removed_size, want.removed_valid,
                         got.removed_valid, want.insert_refused, got.insert_refused);
                $display("  full %b/%b empty %b/%b count %0d/%0d",
                         want.queue_full, got.queue_full, want.queue_empty,
                         got.queue_empty, want.entry_count, got.entry_count);
            end
        end
    endfunction

    // result side: random stall pattern, one long hold-off to back the queue up
    initial begin
        int  r;
        int  stall_left;
        int  quiet_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        quiet_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_results >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (quiet_left > 0) begin
                i_stall = 1'b0;
                quiet_left--;
            end else begin
                r = $urandom_range(0, 99);
                i_stall = 1'b0;
                if (r < 8) begin
                    quiet_left = $urandom_range(20, 150);
                end else if (r < 30) begin
                    i_stall    = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 33) begin
                    i_stall    = 1'b1;
                    stall_left = $urandom_range(10, 60);
                end
            end
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_result();
        end
    end

    initial begin
        int                n_sent;
        int                phase_len;
        int                phase_kind;
        int                ins_pct;
        int                phase_no;
        logic [SIZE_W-1:0] desc_size;
        logic              mode;
        logic [SIZE_W-1:0] size;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[k])
            offer_job(DIRECTED[k].mode, DIRECTED[k].size, DIRECTED[k].typed, DIRECTED[k].res);

        // phases lean towards filling, draining or mixing so both ends are hit often
        n_sent   = 0;
        phase_no = 0;
        while (n_sent < N_RANDOM) begin
            if (phase_no == 2 || $urandom_range(0, 5) == 0) drain_pause();
            phase_kind = (phase_no == 0) ? 0 : $urandom_range(0, 3);
            case (phase_kind)
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 55;
            endcase
            phase_len = $urandom_range(20, 80);
            desc_size = SIZE_W'($urandom_range(600, 1023));
            repeat (phase_len) begin
                mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
                if (phase_kind == 3 && mode == MODE_INSERT) begin
                    // falling sizes make inserts walk back over the larger entries stored earlier in the phase
                    size      = desc_size;
                    desc_size = (desc_size > 20) ? desc_size - SIZE_W'($urandom_range(0, 20))
                                                 : SIZE_W'($urandom_range(0, 1023));
                end else begin
                    size = pick_size();
                end
                offer_job(mode, size, 1'b0, '0);
                n_sent++;
            end
            phase_no++;
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("%0d inserts (%0d refused when full), %0d removes (%0d on empty)",
                 n_inserts, n_refused, n_removes, n_empty_takes);
        $display("%0d results checked, queue full after %0d items", n_results, n_full);
        if (n_mismatch == 0 && n_stray == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     n_mismatch, n_stray, pending_results.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sjfq_pkg.sv
rtl/sjfq_ram.sv
rtl/sjfq_ctrl.sv
rtl/shortest_job_first_queue.sv
tb/testbench.sv
